// ----- sv/page_replacement_engine_defines.svh -----
// Assertion macros for the page replacement engine.
// Used by the top level only; no other dependencies.
`ifndef PAGE_REPLACEMENT_ENGINE_DEFINES_SVH
`define PAGE_REPLACEMENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pre_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants of the page replacement engine: policy codes,
// configuration register indexes and fixed field widths. No dependencies.
package pre_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int FAULT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'd1;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;

    localparam logic [4:0] FRAME_COUNT_RESET = 5'd16;

endpackage

// ----- sv/pre_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/page_replacement_engine.sv -----
`timescale 1ns / 1ps
// Page replacement engine: resident-page lookup with FIFO, LRU and clock eviction.
// Depends on pre_pkg, pre_ram and page_replacement_engine_defines.svh.
// With n active frames and F = FRAMES, every item starts with a lookup scan of the n frames;
// LRU hits and all fills then update the F rank entries, after a victim scan or sweep if full.
// One item at a time: a new page is taken only in idle, after the last result is registered.
// Reset clears valid bits, hand, fault count and output valid; config returns to 16, FIFO.
`include "page_replacement_engine_defines.svh"
module page_replacement_engine #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: page_number
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // tdata: evicted_page, fault_total
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [((PAGE_BITS+39)/8)*8-1:0]    o_m_tdata,
    // tuser: hit, evicted_valid
    output logic [1:0]                         o_m_tuser,
    input  logic                               i_cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pre_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW     = $clog2(FRAMES + 1);
    localparam int RW     = IW;
    localparam int MW     = RW + 1;
    localparam int CW     = (NW > 5) ? NW : 5;
    localparam int OUT_W  = ((PAGE_BITS + 39) / 8) * 8;
    localparam int FW     = pre_pkg::FAULT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLK,
        ST_MAX,
        ST_OLD_RD,
        ST_OLD_WAIT,
        ST_MN,
        ST_COMMIT,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [4:0]           r_frame_count;
    logic [1:0]           r_policy;
    logic [FRAMES-1:0]    r_valid;
    logic [IW-1:0]        r_hand;
    logic [FW-1:0]        r_fault;

    logic [PAGE_BITS-1:0] r_page;
    logic [NW-1:0]        r_cnt;
    logic                 r_pend;
    logic [IW-1:0]        r_pidx;
    logic [IW-1:0]        r_sw;
    logic                 r_stale;
    logic [IW-1:0]        r_f;
    logic                 r_found;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic [RW-1:0]        r_best;
    logic                 r_old_valid;
    logic                 r_old_ref;
    logic [RW-1:0]        r_old_rank;
    logic                 r_hit;
    logic                 r_evict;
    logic [PAGE_BITS-1:0] r_ev_page;

    logic                 r_m_valid;
    logic                 r_m_hit;
    logic                 r_m_ev_valid;
    logic [PAGE_BITS-1:0] r_m_ev_page;
    logic [FW-1:0]        r_m_fault;

    logic [NW-1:0]        w_active;
    logic [CW-1:0]        fc_ext;
    logic [IW-1:0]        page_raddr;
    logic                 page_we;
    logic [PAGE_BITS-1:0] page_rdata;
    logic [IW-1:0]        meta_raddr;
    logic                 meta_we;
    logic [IW-1:0]        meta_waddr;
    logic [MW-1:0]        meta_wdata;
    logic [MW-1:0]        meta_rdata;
    logic                 rd_ref;
    logic [RW-1:0]        rd_rank;
    logic                 clk_ref;
    logic                 new_ref;
    logic [IW-1:0]        sw_next;
    logic [IW-1:0]        sw_start;
    logic [IW-1:0]        n_hand;
    logic                 scan_issue;
    logic                 out_free;

    // Active frame count: zero acts as one, above FRAMES acts as FRAMES.
    always_comb begin
        fc_ext = CW'(r_frame_count);
        if (r_frame_count == 5'd0) begin
            w_active = NW'(1);
        end else if (fc_ext > CW'(FRAMES)) begin
            w_active = NW'(FRAMES);
        end else begin
            w_active = NW'(fc_ext);
        end
    end

    assign rd_ref   = meta_rdata[RW];
    assign rd_rank  = meta_rdata[RW-1:0];
    assign clk_ref  = rd_ref && !r_stale;
    assign new_ref  = r_hit ? r_old_ref : 1'b1;
    assign sw_next  = ((NW'(r_sw) + NW'(1)) == w_active) ? '0 : IW'(NW'(r_sw) + NW'(1));
    assign sw_start = (NW'(r_hand) >= w_active) ? '0 : r_hand;
    assign n_hand   = ((NW'(r_f) + NW'(1)) == w_active) ? '0 : IW'(NW'(r_f) + NW'(1));
    assign scan_issue = (r_cnt < w_active);
    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        page_raddr = r_cnt[IW-1:0];
        page_we    = 1'b0;
        meta_raddr = r_cnt[IW-1:0];
        meta_we    = 1'b0;
        meta_waddr = r_pidx;
        meta_wdata = meta_rdata;
        case (r_state)
            ST_CLK: begin
                meta_raddr = r_sw;
                if (r_pend && clk_ref) begin
                    meta_we    = 1'b1;
                    meta_wdata = {1'b0, rd_rank};
                end
            end
            ST_OLD_RD: begin
                page_raddr = r_f;
                meta_raddr = r_f;
            end
            ST_OLD_WAIT: begin
                if (r_hit && (r_policy == pre_pkg::POL_CLOCK)) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_f;
                    meta_wdata = {1'b1, rd_rank};
                end
            end
            ST_MN: begin
                if (r_pend) begin
                    if (r_pidx == r_f) begin
                        meta_we    = 1'b1;
                        meta_wdata = {new_ref, RW'(0)};
                    end else if (r_valid[r_pidx] && (!r_old_valid || (rd_rank < r_old_rank)))
                    begin
                        meta_we    = 1'b1;
                        meta_wdata = {rd_ref, rd_rank + RW'(1)};
                    end
                end
            end
            ST_COMMIT: begin
                page_we = !r_hit;
            end
            default: ;
        endcase
    end

    pre_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (r_f),
        .i_wdata (r_page),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    pre_ram #(
        .WIDTH (MW),
        .DEPTH (FRAMES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_count <= pre_pkg::FRAME_COUNT_RESET;
            r_policy      <= pre_pkg::POL_FIFO;
            r_valid       <= '0;
            r_hand        <= '0;
            r_fault       <= '0;
            r_m_valid     <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pre_pkg::REG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[4:0];
                    pre_pkg::REG_POLICY_MODE: r_policy      <= i_cfg_wdata[1:0];
                    default: ;
                endcase
            end

            if (r_m_valid && i_m_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_page       <= i_s_tdata[PAGE_BITS-1:0];
                        r_cnt        <= '0;
                        r_pend       <= 1'b0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_hit        <= 1'b0;
                        r_evict      <= 1'b0;
                        r_state      <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    r_pend <= scan_issue;
                    r_pidx <= r_cnt[IW-1:0];
                    if (scan_issue) begin
                        r_cnt <= r_cnt + NW'(1);
                    end
                    if (r_pend) begin
                        if (r_valid[r_pidx] && (page_rdata == r_page) && !r_found) begin
                            r_found <= 1'b1;
                            r_f     <= r_pidx;
                        end
                        if (!r_valid[r_pidx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                    end else if (!scan_issue) begin
                        r_cnt   <= '0;
                        r_best  <= '0;
                        r_stale <= 1'b0;
                        r_sw    <= sw_start;
                        if (r_found) begin
                            r_hit <= 1'b1;
                            if ((r_policy == pre_pkg::POL_CLOCK) ||
                                (r_policy == pre_pkg::POL_LRU)) begin
                                r_state <= ST_OLD_RD;
                            end else begin
                                r_state <= ST_COMMIT;
                            end
                        end else if (r_free_found) begin
                            r_f     <= r_free_idx;
                            r_state <= ST_OLD_RD;
                        end else begin
                            r_evict <= 1'b1;
                            if (r_policy == pre_pkg::POL_CLOCK) begin
                                r_state <= ST_CLK;
                            end else begin
                                r_state <= ST_MAX;
                            end
                        end
                    end
                end
                ST_CLK: begin
                    r_pend  <= 1'b1;
                    r_pidx  <= r_sw;
                    r_sw    <= sw_next;
                    r_stale <= r_pend && clk_ref && (r_sw == r_pidx);
                    if (r_pend && !clk_ref) begin
                        r_f     <= r_pidx;
                        r_pend  <= 1'b0;
                        r_state <= ST_OLD_RD;
                    end
                end
                ST_MAX: begin
                    r_pend <= scan_issue;
                    r_pidx <= r_cnt[IW-1:0];
                    if (scan_issue) begin
                        r_cnt <= r_cnt + NW'(1);
                    end
                    if (r_pend) begin
                        if (rd_rank >= r_best) begin
                            r_best <= rd_rank;
                            r_f    <= r_pidx;
                        end
                    end else if (!scan_issue) begin
                        r_state <= ST_OLD_RD;
                    end
                end
                ST_OLD_RD: begin
                    r_state <= ST_OLD_WAIT;
                end
                ST_OLD_WAIT: begin
                    r_old_valid <= r_valid[r_f];
                    r_old_ref   <= rd_ref;
                    r_old_rank  <= rd_rank;
                    r_ev_page   <= page_rdata;
                    r_cnt       <= '0;
                    r_pend      <= 1'b0;
                    if (r_hit && (r_policy == pre_pkg::POL_CLOCK)) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_state <= ST_MN;
                    end
                end
                ST_MN: begin
                    r_pend <= (r_cnt < NW'(FRAMES));
                    r_pidx <= r_cnt[IW-1:0];
                    if (r_cnt < NW'(FRAMES)) begin
                        r_cnt <= r_cnt + NW'(1);
                    end else if (!r_pend) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (!r_hit) begin
                        r_valid[r_f] <= 1'b1;
                        if (r_fault != '1) begin
                            r_fault <= r_fault + FW'(1);
                        end
                        if (r_policy == pre_pkg::POL_CLOCK) begin
                            r_hand <= n_hand;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_valid    <= 1'b1;
                        r_m_hit      <= r_hit;
                        r_m_ev_valid <= r_evict;
                        r_m_ev_page  <= r_evict ? r_ev_page : '0;
                        r_m_fault    <= r_fault;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'({r_m_fault, r_m_ev_page});
    assign o_m_tuser  = {r_m_ev_valid, r_m_hit};

    `PRE_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != ST_IDLE, "accepted item did not start work")
    `PRE_ASSERT_NOW(a_frame_active, i_clk, i_rst_n, r_state == ST_OLD_RD, NW'(r_f) < w_active, "selected frame outside active range")
    `PRE_ASSERT_NEXT(a_hit_keeps_faults, i_clk, i_rst_n, (r_state == ST_COMMIT) && r_hit, r_fault == $past(r_fault), "fault count changed on a hit")

endmodule

// ----- bench/page_replacement_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for page_replacement_engine: a directed table, then random reference
// streams under FIFO, LRU, clock and the spare policy code. Depends on pre_pkg and the RTL.
module page_replacement_engine_tb;

    localparam int          FRAMES      = 16;
    localparam int          PAGE_W      = 16;
    localparam int          M_DATA_W    = 48;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  POL_SPARE   = 2'd3;

    typedef struct packed {
        logic              hit;
        logic              ev_valid;
        logic [PAGE_W-1:0] ev_page;
        logic [31:0]       faults;
    } t_page_outcome;

    typedef struct {
        bit                              is_cfg;
        logic [pre_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [pre_pkg::CFG_DATA_W-1:0]  reg_value;
        logic [PAGE_W-1:0]               page;
        bit                              known;
        t_page_outcome                   known_out;
    } t_plan_row;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [PAGE_W-1:0]               i_s_tdata   = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]             o_m_tdata;
    logic [1:0]                      o_m_tuser;
    logic                            i_cfg_we    = 1'b0;
    logic [pre_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [pre_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    // Resident-page table as the block should hold it.
    logic [PAGE_W-1:0]  res_page  [FRAMES];
    bit                 res_valid [FRAMES];
    bit                 use_bit   [FRAMES];
    logic [3:0]         age_rank  [FRAMES];
    logic [3:0]         sweep_hand  = '0;
    logic [31:0]        fault_tally = '0;
    logic [4:0]         cfg_frames  = pre_pkg::FRAME_COUNT_RESET;
    logic [1:0]         cfg_policy  = pre_pkg::POL_FIFO;

    t_page_outcome      pending_outcomes [$];
    t_plan_row          plan_rows [$];
    logic [1:0]         policy_cycle [4] = '{pre_pkg::POL_FIFO, pre_pkg::POL_LRU,
                                             pre_pkg::POL_CLOCK, POL_SPARE};
    bit                 steady         = 1'b0;
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;

    page_replacement_engine #(
        .FRAMES   (FRAMES),
        .PAGE_BITS(PAGE_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // page_number
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // evicted_page, fault_total
        .o_m_tuser  (o_m_tuser),    // hit, evicted_valid
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            res_page[i]  = '0;
            res_valid[i] = 1'b0;
            use_bit[i]   = 1'b0;
            age_rank[i]  = '0;
        end
    end

    function automatic void promote_frame(int f);
        int old_rank;
        old_rank = res_valid[f] ? int'(age_rank[f]) : FRAMES;
        for (int i = 0; i < FRAMES; i++) begin
            if (i != f && res_valid[i] && int'(age_rank[i]) < old_rank) age_rank[i]++;
        end
        age_rank[f] = '0;
    endfunction

    function automatic t_page_outcome resolve_reference(logic [PAGE_W-1:0] page);
        t_page_outcome r;
        int n, f, h, top;
        bit found, free_found;
        r = '0;
        n = (cfg_frames == 0) ? 1 : (cfg_frames > FRAMES) ? FRAMES : int'(cfg_frames);
        found = 1'b0;
        f = 0;
        for (int i = 0; i < n && !found; i++) begin
            if (res_valid[i] && res_page[i] == page) begin
                f = i;
                found = 1'b1;
            end
        end
        if (found) begin
            if (cfg_policy == pre_pkg::POL_CLOCK) use_bit[f] = 1'b1;
            else if (cfg_policy == pre_pkg::POL_LRU) promote_frame(f);
            r.hit = 1'b1;
            r.faults = fault_tally;
            return r;
        end
        free_found = 1'b0;
        for (int i = 0; i < n && !free_found; i++) begin
            if (!res_valid[i]) begin
                f = i;
                free_found = 1'b1;
            end
        end
        if (!free_found) begin
            if (cfg_policy == pre_pkg::POL_CLOCK) begin
                h = (int'(sweep_hand) >= n) ? 0 : int'(sweep_hand);
                while (use_bit[h]) begin
                    use_bit[h] = 1'b0;
                    h = (h + 1) % n;
                end
                f = h;
            end else begin
                top = 0;
                f = 0;
                for (int i = 0; i < n; i++) begin
                    if (int'(age_rank[i]) >= top) begin
                        top = int'(age_rank[i]);
                        f = i;
                    end
                end
            end
            r.ev_valid = 1'b1;
            r.ev_page  = res_page[f];
        end
        promote_frame(f);
        res_page[f]  = page;
        res_valid[f] = 1'b1;
        use_bit[f]   = 1'b1;
        if (cfg_policy == pre_pkg::POL_CLOCK) sweep_hand = 4'((f + 1) % n);
        if (fault_tally != '1) fault_tally++;
        r.faults = fault_tally;
        return r;
    endfunction

    function automatic void plan_cfg(logic [pre_pkg::CFG_IDX_W-1:0] idx,
                                     logic [pre_pkg::CFG_DATA_W-1:0] value);
        t_plan_row row;
        row.is_cfg    = 1'b1;
        row.reg_idx   = idx;
        row.reg_value = value;
        row.page      = '0;
        row.known     = 1'b0;
        row.known_out = '0;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void plan_page(logic [PAGE_W-1:0] page);
        t_plan_row row;
        row.is_cfg    = 1'b0;
        row.reg_idx   = '0;
        row.reg_value = '0;
        row.page      = page;
        row.known     = 1'b0;
        row.known_out = '0;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void plan_known(logic [PAGE_W-1:0] page, logic hit, logic ev_valid,
                                       logic [PAGE_W-1:0] ev_page, logic [31:0] faults);
        t_plan_row row;
        row.is_cfg             = 1'b0;
        row.reg_idx            = '0;
        row.reg_value          = '0;
        row.page               = page;
        row.known              = 1'b1;
        row.known_out.hit      = hit;
        row.known_out.ev_valid = ev_valid;
        row.known_out.ev_page  = ev_page;
        row.known_out.faults   = faults;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic drain_results();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [pre_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pre_pkg::CFG_DATA_W-1:0] value);
        i_s_tvalid <= 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pre_pkg::REG_FRAME_COUNT) cfg_frames = value;
        else cfg_policy = value[1:0];
    endtask

    task automatic send_reference(logic [PAGE_W-1:0] page, bit known, t_page_outcome known_out);
        t_page_outcome predicted;
        if (!steady && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= page;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = resolve_reference(page);
        pending_outcomes.insert(pending_outcomes.size(), known ? known_out : predicted);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= i_rst_n && (steady || $urandom_range(0, 99) >= 37);
    end

    always @(posedge i_clk) begin
        t_page_outcome want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected item", o_m_tdata, 0);
            end else begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                if (o_m_tuser[0] !== want.hit)
                    report_mismatch("hit", o_m_tuser[0], want.hit);
                if (o_m_tuser[1] !== want.ev_valid)
                    report_mismatch("evicted_valid", o_m_tuser[1], want.ev_valid);
                if (o_m_tdata[15:0] !== want.ev_page)
                    report_mismatch("evicted_page", o_m_tdata[15:0], want.ev_page);
                if (o_m_tdata[47:16] !== want.faults)
                    report_mismatch("fault_total", o_m_tdata[47:16], want.faults);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [PAGE_W-1:0]               base;
        logic [PAGE_W-1:0]               page;
        logic [pre_pkg::CFG_DATA_W-1:0]  frames;
        logic [1:0]                      policy;
        int                              span;
        int                              active;

        // two frames, FIFO: fill, hit, evict the oldest load
        plan_cfg(pre_pkg::REG_FRAME_COUNT, 5'd2);
        plan_known(16'h0000, 1'b0, 1'b0, 16'h0000, 32'd1);
        plan_known(16'hFFFF, 1'b0, 1'b0, 16'h0000, 32'd2);
        plan_known(16'h0000, 1'b1, 1'b0, 16'h0000, 32'd2);
        plan_known(16'h1234, 1'b0, 1'b1, 16'h0000, 32'd3);
        plan_known(16'hFFFF, 1'b1, 1'b0, 16'h0000, 32'd3);
        plan_cfg(pre_pkg::REG_POLICY_MODE, {3'd0, pre_pkg::POL_LRU});
        plan_known(16'hABCD, 1'b0, 1'b1, 16'hFFFF, 32'd4);
        plan_known(16'h1234, 1'b1, 1'b0, 16'h0000, 32'd4);
        plan_page(16'h5555);
        plan_cfg(pre_pkg::REG_POLICY_MODE, {3'd0, pre_pkg::POL_CLOCK});
        plan_page(16'h1234);
        plan_page(16'h8000);
        plan_page(16'h0001);
        plan_page(16'h8000);
        plan_cfg(pre_pkg::REG_POLICY_MODE, {3'd0, POL_SPARE});
        plan_page(16'h4321);
        plan_page(16'h1234);
        // zero frames acts as one; then grow past the table to expose a duplicate
        plan_cfg(pre_pkg::REG_FRAME_COUNT, 5'd0);
        plan_page(16'h1234);
        plan_cfg(pre_pkg::REG_FRAME_COUNT, 5'd31);
        plan_page(16'h1234);
        plan_page(16'h00FF);
        plan_cfg(pre_pkg::REG_FRAME_COUNT, 5'd16);
        plan_page(16'hFFFF);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_rows[k]) begin
            if (plan_rows[k].is_cfg)
                write_register(plan_rows[k].reg_idx, plan_rows[k].reg_value);
            else
                send_reference(plan_rows[k].page, plan_rows[k].known, plan_rows[k].known_out);
        end

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: frames = 5'd16;
                1: frames = 5'd1;
                2: frames = 5'd31;
                3: frames = 5'd0;
                default: frames = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                              : 5'($urandom_range(1, 16));
            endcase
            policy = (ph < 8) ? policy_cycle[ph % 4] : policy_cycle[$urandom_range(0, 3)];
            write_register(pre_pkg::REG_FRAME_COUNT, frames);
            write_register(pre_pkg::REG_POLICY_MODE, {3'd0, policy});
            steady = (ph == 6);
            active = (frames == 0) ? 1 : (frames > FRAMES) ? FRAMES : int'(frames);
            span = active + $urandom_range(1, 6);
            base = 16'($urandom_range(0, 65535));
            for (int k = 0; k < 150; k++) begin
                if (ph == 5 && k == 75) begin
                    i_s_tvalid <= 1'b0;
                    drain_results();
                end
                if ($urandom_range(0, 9) == 0) page = 16'($urandom_range(0, 65535));
                else page = base ^ 16'($urandom_range(0, span - 1));
                send_reference(page, 1'b0, '0);
            end
        end
        steady = 1'b0;

        i_s_tvalid <= 1'b0;
        drain_results();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pre_pkg.sv
sv/pre_ram.sv
sv/page_replacement_engine.sv
bench/page_replacement_engine_tb.sv
